FILE: hdl/npd_pkg.sv
// ----------------------------------------------------------------------------
// npd_pkg
// Shared types and constants of the netpbm pixel decoder.
// ----------------------------------------------------------------------------
package npd_pkg;

  // Pixel format codes.
  localparam logic [2:0] FMT_BITMAP = 3'd0;
  localparam logic [2:0] FMT_GRAY   = 3'd1;
  localparam logic [2:0] FMT_GRAYA  = 3'd2;
  localparam logic [2:0] FMT_RGB    = 3'd3;
  localparam logic [2:0] FMT_RGBA   = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_MAXVAL = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  localparam int DIV_STEPS = 24;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BITS,
    ST_DIV,
    ST_SAMPLE,
    ST_OUT
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load_byte;   // capture input byte
    logic div_start;   // start scaling the sample
    logic div_step;    // one divider step
    logic bit_emit;    // build bitmap pixel into output register
    logic smp_emit;    // build sample pixel into output register
    logic smp_hold;    // store sample into held channel
    logic adv_pos;     // advance column/row
    logic next_bit;    // move to next bitmap bit
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic row_end;     // next pixel ends the row
    logic bit_last;    // current bit is bit 0
    logic div_done;
  } sts_t;

endpackage

FILE: hdl/binary_netpbm_pixel_decoder_unit.sv
// ----------------------------------------------------------------------------
// binary_netpbm_pixel_decoder_unit
// Decodes binary netpbm raster bytes into RGBA8 pixels.
// ----------------------------------------------------------------------------
// Channel | Direction | Contents
// in_     | slave     | tdata[7:0] data_byte
// out_    | master    | tdata red,green,blue,alpha; tuser last_of_item,end_of_image
// cfg_    | write     | 0 format, 1 max_value, 2 width, 3 height
//
// A bitmap byte gives one pixel per bit, down to bit 0 or to the end of the row.
// A sample byte is scaled by the 24-step restoring divider and then held as a
// channel or used to complete a pixel; a high byte of a 16-bit sample is only
// stored. One item is worked on at a time. Reset is synchronous; a stalled
// output holds the controller.
module binary_netpbm_pixel_decoder_unit #(
  parameter int DIM_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // red, green, blue, alpha from bit 0 up
  output logic [1:0]  out_tuser,   // last_of_item, end_of_image from bit 0 up
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [2:0]  fmt_r;
  logic [15:0] maxv_r;
  logic [DIM_BITS-1:0] width_r, height_r;
  npd_pkg::cmd_t cmd;
  npd_pkg::sts_t sts;
  logic wide, phase, out_free, busy, in_fire;
  logic [1:0]  slot;
  logic [33:0] odata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= npd_pkg::FMT_RGB;
      maxv_r   <= 16'd255;
      width_r  <= DIM_BITS'(1);
      height_r <= DIM_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        npd_pkg::REG_FORMAT: fmt_r    <= cfg_wdata[2:0];
        npd_pkg::REG_MAXVAL: maxv_r   <= cfg_wdata;
        npd_pkg::REG_WIDTH:  width_r  <= DIM_BITS'(cfg_wdata);
        npd_pkg::REG_HEIGHT: height_r <= DIM_BITS'(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;

  npd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .fmt(fmt_r), .wide(wide),
    .phase(phase), .slot(slot), .out_free(out_free), .sts(sts), .cmd(cmd),
    .busy(busy)
  );

  npd_datapath #(.DIM_BITS(DIM_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_byte(in_tdata), .fmt(fmt_r),
    .max_value(maxv_r), .width(width_r), .height(height_r),
    .out_ready(out_tready), .sts(sts), .wide(wide), .phase(phase),
    .slot(slot), .out_free(out_free), .out_valid(out_tvalid), .out_data(odata)
  );

  assign out_tdata = odata[31:0];
  assign out_tuser = odata[33:32];

endmodule

FILE: hdl/npd_ctrl.sv
// ----------------------------------------------------------------------------
// npd_ctrl
// Controller state machine of the netpbm pixel decoder.
// ----------------------------------------------------------------------------
module npd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic [2:0]    fmt,
  input  logic          wide,
  input  logic          phase,
  input  logic [1:0]    slot,
  input  logic          out_free,
  input  npd_pkg::sts_t sts,
  output npd_pkg::cmd_t cmd,
  output logic          busy
);

  npd_pkg::state_t state_r, state_nxt;
  logic [2:0] nch;

  // Channel count of the current format.
  always_comb begin
    case (fmt)
      npd_pkg::FMT_GRAY:  nch = 3'd1;
      npd_pkg::FMT_GRAYA: nch = 3'd2;
      npd_pkg::FMT_RGBA:  nch = 3'd4;
      default:            nch = 3'd3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= npd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      npd_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          cmd.load_byte = 1'b1;
          if (fmt == npd_pkg::FMT_BITMAP) begin
            state_nxt = npd_pkg::ST_BITS;
          end else if (!wide || phase) begin
            cmd.div_start = 1'b1;
            state_nxt = npd_pkg::ST_DIV;
          end
        end
      end
      npd_pkg::ST_BITS: begin
        if (out_free) begin
          cmd.bit_emit = 1'b1;
          cmd.adv_pos  = 1'b1;
          cmd.next_bit = 1'b1;
          if (sts.bit_last || sts.row_end) begin
            state_nxt = npd_pkg::ST_IDLE;
          end
        end
      end
      npd_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = npd_pkg::ST_SAMPLE;
        end
      end
      npd_pkg::ST_SAMPLE: begin
        if ({1'b0, slot} + 3'd1 < nch) begin
          cmd.smp_hold = 1'b1;
          state_nxt = npd_pkg::ST_IDLE;
        end else begin
          state_nxt = npd_pkg::ST_OUT;
        end
      end
      npd_pkg::ST_OUT: begin
        if (out_free) begin
          cmd.smp_emit = 1'b1;
          cmd.adv_pos  = 1'b1;
          state_nxt = npd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = npd_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: hdl/npd_datapath.sv
// ----------------------------------------------------------------------------
// npd_datapath
// Sample storage, restoring divider, position counters and output register.
// ----------------------------------------------------------------------------
module npd_datapath #(
  parameter int DIM_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  npd_pkg::cmd_t cmd,
  input  logic [7:0]    in_byte,
  input  logic [2:0]    fmt,
  input  logic [15:0]   max_value,
  input  logic [DIM_BITS-1:0] width,
  input  logic [DIM_BITS-1:0] height,
  input  logic          out_ready,
  output npd_pkg::sts_t sts,
  output logic          wide,
  output logic          phase,
  output logic [1:0]    slot,
  output logic          out_free,
  output logic          out_valid,
  output logic [33:0]   out_data
);

  logic [7:0]  byte_r, hold_r;
  logic        phase_r;
  logic [1:0]  slot_r;
  logic [7:0]  held_r [3];
  logic [2:0]  bit_r;
  logic [DIM_BITS-1:0] col_r, row_r;
  logic [23:0] num_r;      // dividend shifts out, quotient shifts in
  logic [16:0] rem_r;
  logic [4:0]  cnt_r;
  logic        sat_r;
  logic        ovalid_r;
  logic [33:0] odata_r;

  logic [15:0] m, v;
  logic [DIM_BITS-1:0] w, h;
  logic [16:0] trial;
  logic [7:0]  s, c;
  logic        eoi;
  logic        pix_last;

  assign m     = (max_value == 16'd0) ? 16'd1 : max_value;
  assign w     = (width  == '0) ? DIM_BITS'(1) : width;
  assign h     = (height == '0) ? DIM_BITS'(1) : height;
  assign wide  = (max_value > 16'd255);
  assign phase = phase_r;
  assign slot  = slot_r;
  // The divider starts in the cycle that the byte is accepted, so the sample
  // is built from the incoming byte.
  assign v     = wide ? {hold_r, in_byte} : {8'd0, in_byte};

  assign sts.row_end  = ({1'b0, col_r} + 1'b1) >= {1'b0, w};
  assign sts.bit_last = (bit_r == 3'd0);
  assign sts.div_done = (cnt_r == 5'd0);
  assign eoi          = sts.row_end && (({1'b0, row_r} + 1'b1) >= {1'b0, h});
  assign s            = sat_r ? 8'hFF : num_r[7:0];
  assign c            = byte_r[bit_r] ? 8'h00 : 8'hFF;
  assign pix_last     = sts.bit_last || sts.row_end;

  assign trial     = {rem_r[15:0], num_r[23]} - {1'b0, m};
  assign out_free  = !ovalid_r || out_ready;
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  // Byte capture, 16-bit sample assembly and bit pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r  <= '0;
      phase_r <= 1'b0;
      bit_r   <= 3'd7;
    end else begin
      if (cmd.load_byte) begin
        byte_r <= in_byte;
        bit_r  <= 3'd7;
        if (fmt != npd_pkg::FMT_BITMAP) begin
          if (wide && !phase_r) begin
            hold_r  <= in_byte;
            phase_r <= 1'b1;
          end else begin
            phase_r <= 1'b0;
          end
        end
      end
      if (cmd.next_bit) begin
        bit_r <= bit_r - 3'd1;
      end
    end
  end

  // Restoring divider for v*255/m, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.div_start) begin
      num_r <= 24'({v, 8'd0} - {8'd0, v});
      rem_r <= '0;
      cnt_r <= 5'(npd_pkg::DIV_STEPS);
      sat_r <= (v > m);
    end else if (cmd.div_step && cnt_r != 5'd0) begin
      cnt_r <= cnt_r - 5'd1;
      if (!trial[16]) begin
        rem_r <= trial;
        num_r <= {num_r[22:0], 1'b1};
      end else begin
        rem_r <= {rem_r[15:0], num_r[23]};
        num_r <= {num_r[22:0], 1'b0};
      end
    end
  end

  // Held channels and slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      for (int i = 0; i < 3; i++) begin
        held_r[i] <= '0;
      end
    end else if (cmd.smp_hold) begin
      held_r[slot_r] <= s;
      slot_r <= slot_r + 2'd1;
    end else if (cmd.smp_emit) begin
      slot_r <= '0;
    end
  end

  // Position counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.adv_pos) begin
      if (sts.row_end) begin
        col_r <= '0;
        row_r <= eoi ? '0 : row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  // Output register: {eoi, last, alpha, blue, green, red}.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      if (cmd.bit_emit) begin
        ovalid_r <= 1'b1;
        odata_r  <= {eoi, pix_last, 8'hFF, c, c, c};
      end else if (cmd.smp_emit) begin
        ovalid_r <= 1'b1;
        case (fmt)
          npd_pkg::FMT_GRAY:  odata_r <= {eoi, 1'b1, 8'hFF, s, s, s};
          npd_pkg::FMT_GRAYA: odata_r <= {eoi, 1'b1, s, held_r[0], held_r[0], held_r[0]};
          npd_pkg::FMT_RGBA:  odata_r <= {eoi, 1'b1, s, held_r[2], held_r[1], held_r[0]};
          default:            odata_r <= {eoi, 1'b1, 8'hFF, s, held_r[1], held_r[0]};
        endcase
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/npd_checker.sv
// ----------------------------------------------------------------------------
// npd_checker
// Port-level checks of the netpbm pixel decoder.
// ----------------------------------------------------------------------------
module npd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The end of an image is always the last pixel of its byte.
  a_eoi: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("end of image without last of item");

  // The handshake outputs stay defined after an accepted item.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$isunknown(in_tready) && !$isunknown(out_tvalid))
    else $error("handshake output undefined");

  // No result is shown right after reset.
  a_rst: assert property (@(posedge clk) $rose(rst_n) |-> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind binary_netpbm_pixel_decoder_unit npd_checker u_npd_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);

FILE: verif/binary_netpbm_pixel_decoder_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_netpbm_pixel_decoder_unit_test
// Self-checking regression of the netpbm raster decoder. Raster bytes are
// driven through the input stream under several register settings; a local
// model of the decoder predicts every RGBA pixel and its flags, and each
// pixel leaving the block is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module binary_netpbm_pixel_decoder_unit_test;

  localparam string PASS_MSG = "binary_netpbm_pixel_decoder_unit regression: pass";
  localparam string FAIL_MSG = "binary_netpbm_pixel_decoder_unit regression: fail";
  localparam int    WATCHDOG = 20000;
  localparam int    DRAIN    = 60;

  typedef struct packed {
    logic       eoi;
    logic       last;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  binary_netpbm_pixel_decoder_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the registers and the decoder state.
  logic [2:0]  fmt_q;
  logic [15:0] maxv_q, width_q, height_q;
  logic [7:0]  hi_byte_q;
  logic        phase_q;
  logic [1:0]  slot_q;
  logic [7:0]  held_q [3];
  logic [15:0] col_q, row_q;

  pixel_t pixel_queue [$];
  int     mismatches = 0;
  int     idle_cycles = 0;
  bit     timed_out = 1'b0;
  bit     rx_hold = 1'b0;

  function automatic logic [7:0] scale(input logic [15:0] v);
    logic [31:0] m;
    m = (maxv_q == 0) ? 32'd1 : {16'd0, maxv_q};
    if (v > m) return 8'hFF;
    return 8'(({16'd0, v} * 32'd255) / m);
  endfunction

  // Steps the position counters; returns row end and sets the image end flag.
  function automatic bit step_position(output logic eoi);
    logic [16:0] w, h;
    w = (width_q == 0) ? 17'd1 : {1'b0, width_q};
    h = (height_q == 0) ? 17'd1 : {1'b0, height_q};
    eoi = 1'b0;
    if ({1'b0, col_q} + 17'd1 >= w) begin
      col_q = '0;
      if ({1'b0, row_q} + 17'd1 >= h) begin
        row_q = '0;
        eoi = 1'b1;
      end else begin
        row_q = row_q + 16'd1;
      end
      return 1'b1;
    end
    col_q = col_q + 16'd1;
    return 1'b0;
  endfunction

  task automatic predict_pixels(input logic [7:0] byte_in);
    pixel_t     px;
    logic       eoi, row_end;
    logic [7:0] c, s;
    logic [15:0] v;
    int         nch;
    if (fmt_q == npd_pkg::FMT_BITMAP) begin
      for (int bit_i = 7; bit_i >= 0; bit_i--) begin
        c = byte_in[bit_i] ? 8'h00 : 8'hFF;
        row_end = step_position(eoi);
        px = '{eoi: eoi, last: (bit_i == 0) || row_end, a: 8'hFF, b: c, g: c, r: c};
        pixel_queue.push_back(px);
        if (px.last) break;
      end
      return;
    end
    if (maxv_q > 16'd255) begin
      if (!phase_q) begin
        hi_byte_q = byte_in;
        phase_q = 1'b1;
        return;
      end
      phase_q = 1'b0;
      v = {hi_byte_q, byte_in};
    end else begin
      phase_q = 1'b0;
      v = {8'd0, byte_in};
    end
    s = scale(v);
    nch = (fmt_q == npd_pkg::FMT_GRAY) ? 1 : (fmt_q == npd_pkg::FMT_GRAYA) ? 2 :
          (fmt_q == npd_pkg::FMT_RGBA) ? 4 : 3;
    if (int'(slot_q) + 1 < nch) begin
      held_q[slot_q] = s;
      slot_q = slot_q + 2'd1;
      return;
    end
    slot_q = '0;
    void'(step_position(eoi));
    case (nch)
      1: px = '{eoi: eoi, last: 1'b1, a: 8'hFF, b: s, g: s, r: s};
      2: px = '{eoi: eoi, last: 1'b1, a: s, b: held_q[0], g: held_q[0], r: held_q[0]};
      3: px = '{eoi: eoi, last: 1'b1, a: 8'hFF, b: s, g: held_q[1], r: held_q[0]};
      default: px = '{eoi: eoi, last: 1'b1, a: s, b: held_q[2], g: held_q[1], r: held_q[0]};
    endcase
    pixel_queue.push_back(px);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      npd_pkg::REG_FORMAT: fmt_q    = val[2:0];
      npd_pkg::REG_MAXVAL: maxv_q   = val;
      npd_pkg::REG_WIDTH:  width_q  = val;
      default:             height_q = val;
    endcase
  endtask

  // Waits until every predicted pixel has left, then lets a sample byte finish.
  task automatic wait_drained();
    while (pixel_queue.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic set_mode(input logic [2:0] f, input logic [15:0] m,
                          input logic [15:0] w, input logic [15:0] h);
    wait_drained();
    write_reg(npd_pkg::REG_FORMAT, {13'd0, f});
    write_reg(npd_pkg::REG_MAXVAL, m);
    write_reg(npd_pkg::REG_WIDTH, w);
    write_reg(npd_pkg::REG_HEIGHT, h);
  endtask

  // Sends one byte, after a random gap if asked; prediction happens on acceptance.
  task automatic send_byte(input logic [7:0] b, input bit gaps);
    if (gaps) repeat ($urandom_range(0, 17)) @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_pixels(b);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int wait_n;
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        out_tready = 1'b0;
        repeat (300) @(negedge clk);
        rx_hold = 1'b0;
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if ($urandom_range(0, 2) == 0) wait_n = 0;
      out_tready = 1'b0;
      repeat (wait_n) @(negedge clk);
      out_tready = 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Pixel checker.
  always @(posedge clk) begin
    pixel_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser[1], out_tuser[0], out_tdata[31:24], out_tdata[23:16],
             out_tdata[15:8], out_tdata[7:0]};
      if (pixel_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected pixel %h", got);
      end else begin
        want = pixel_queue.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Pixel mismatch: expected r=%h g=%h b=%h a=%h last=%b eoi=%b, got r=%h g=%h b=%h a=%h last=%b eoi=%b",
                     want.r, want.g, want.b, want.a, want.last, want.eoi,
                     got.r, got.g, got.b, got.a, got.last, got.eoi);
        end
      end
    end
  end

  // Watchdog on cycles with no item moving on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG && !timed_out) begin
      timed_out = 1'b1;
      $display(FAIL_MSG);
      $finish;
    end
  end

  typedef struct {
    logic [7:0] data;
    bit         typed;
    pixel_t     pix;
  } step_row_t;

  initial begin
    step_row_t rows [12];
    logic [2:0] f;
    logic [15:0] m;
    fmt_q = npd_pkg::FMT_RGB; maxv_q = 16'd255; width_q = 16'd1; height_q = 16'd1;
    hi_byte_q = '0; phase_q = 1'b0; slot_q = '0; held_q = '{default: '0};
    col_q = '0; row_q = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset rgb then bitmap extremes with typed results.
    rows[0] = '{8'h00, 1'b0, '0};
    rows[1] = '{8'hFF, 1'b0, '0};
    rows[2] = '{8'h80, 1'b1, '{eoi: 1'b1, last: 1'b1, a: 8'hFF, b: 8'h80, g: 8'hFF, r: 8'h00}};
    for (int i = 0; i < 3; i++) begin
      send_byte(rows[i].data, 1'b1);
      if (rows[i].typed && (pixel_queue.size() == 0 || pixel_queue[$] !== rows[i].pix)) begin
        mismatches++;
        $display("Directed row %0d: predictor disagrees with table", i);
      end
    end
    set_mode(npd_pkg::FMT_BITMAP, 16'd1, 16'd3, 16'd2);
    send_byte(8'hA5, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_drained();
    write_reg(npd_pkg::REG_WIDTH, 16'd0);
    send_byte(8'h5A, 1'b1);
    set_mode(npd_pkg::FMT_BITMAP, 16'd1, 16'd65535, 16'd65535);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // Gray with a zero maximum, wide gray alpha and rgba, undefined format.
    set_mode(npd_pkg::FMT_GRAY, 16'd0, 16'd2, 16'd2);
    send_byte(8'h00, 1'b1); send_byte(8'h01, 1'b1); send_byte(8'hFF, 1'b1);
    set_mode(npd_pkg::FMT_GRAYA, 16'd65535, 16'd2, 16'd1);
    send_byte(8'hFF, 1'b1); send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1); send_byte(8'h01, 1'b1);
    set_mode(npd_pkg::FMT_RGBA, 16'd300, 16'd1, 16'd1);
    for (int i = 0; i < 8; i++) send_byte(i[0] ? 8'hFF : 8'h01, 1'b1);
    set_mode(3'd7, 16'd100, 16'd2, 16'd1);
    send_byte(8'd50, 1'b1); send_byte(8'd100, 1'b1); send_byte(8'd200, 1'b1);

    // Random phases; one with a long receiver hold-off, another with the sender pausing.
    for (int ph = 0; ph < 10; ph++) begin
      f = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
        0: m = 16'd255;
        1: m = 16'd65535;
        2: m = 16'($urandom_range(1, 255));
        default: m = 16'($urandom_range(0, 65535));
      endcase
      set_mode(f, m, 16'($urandom_range(0, 9)), 16'($urandom_range(0, 4)));
      if (ph == 3) rx_hold = 1'b1;
      for (int k = 0; k < 35; k++) begin
        send_byte(8'($urandom_range(0, 255)), (ph != 3) && ($urandom_range(0, 3) != 0));
        if (ph == 5 && k == 17) wait_drained();
      end
    end

    wait_drained();
    if (mismatches == 0 && pixel_queue.size() == 0) begin
      $display(PASS_MSG);
    end else begin
      $display(FAIL_MSG);
    end
    $finish;
  end

endmodule
